// ===== design/b2s_pkg.sv =====
`timescale 1ns / 1ps

package b2s_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 10;

    localparam logic [3:0] LAST_ROUND = 4'(ROUNDS - 1);
    localparam logic [3:0] LAST_HS    = 4'd15;

    localparam logic [5:0] DL_RESET = 6'd32;
    localparam logic [5:0] DL_MAX   = 6'd32;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PARAM_FANOUT_DEPTH = 32'h01010000;

    localparam logic [3:0] SIGMA [10][16] = '{
        '{ 4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
           4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15 },
        '{ 4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
           4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3 },
        '{ 4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
           4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4 },
        '{ 4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
           4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8 },
        '{ 4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
           4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13 },
        '{ 4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
           4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9 },
        '{ 4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
           4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11 },
        '{ 4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
           4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10 },
        '{ 4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
           4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5 },
        '{ 4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
           4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0 }
    };

    typedef struct packed {
        logic       wr_byte;
        logic       wr_pending;
        logic       start_comp;
        logic       is_final;
        logic       init_v;
        logic       mix;
        logic       fold;
        logic       restart;
        logic [3:0] hs;
        logic [3:0] rd_round;
        logic [3:0] rd_hs;
        logic [2:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic [2:0] last_idx;
    } sts_t;

    function automatic logic [3:0] sigma_idx(input logic [3:0] rnd, input logic [3:0] pos);
        logic [3:0] res;
        res = '0;
        if (rnd <= LAST_ROUND)
        begin
            res = SIGMA[rnd][pos];
        end
        return res;
    endfunction

endpackage

// ===== design/b2s_if.sv =====
`timescale 1ns / 1ps

interface b2s_msg_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    modport source (output valid, command, data_byte, input ready);
    modport sink (input valid, command, data_byte, output ready);
endinterface

interface b2s_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface b2s_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] out_len;
    modport source (output valid, out_len, input ready);
    modport sink (input valid, out_len, output ready);
endinterface

// ===== design/b2s_ctrl.sv =====
`timescale 1ns / 1ps

module b2s_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            msg_valid,
    input  logic            msg_command,
    output logic            msg_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  b2s_pkg::sts_t   sts,
    output b2s_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_MIX   = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic [3:0] hs_reg, hs_next;
    logic [2:0] k_reg, k_next;
    logic       pend_reg, pend_next;
    logic       msg_fire;
    logic       last_step;

    assign msg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign msg_fire  = msg_valid && msg_ready;
    assign last_step = (round_reg == b2s_pkg::LAST_ROUND) && (hs_reg == b2s_pkg::LAST_HS);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        hs_next    = hs_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.hs     = hs_reg;
        cmd.out_idx = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_fire)
                begin
                    if (!msg_command && !sts.full)
                    begin
                        cmd.wr_byte = 1'b1;
                    end
                    else
                    begin
                        cmd.start_comp = 1'b1;
                        cmd.is_final   = msg_command;
                        pend_next      = !msg_command;
                        state_next     = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                cmd.init_v = 1'b1;
                round_next = '0;
                hs_next    = '0;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                if (last_step)
                begin
                    state_next = S_FOLD;
                end
                else if (hs_reg == b2s_pkg::LAST_HS)
                begin
                    round_next = round_reg + 4'd1;
                    hs_next    = '0;
                end
                else
                begin
                    hs_next = hs_reg + 4'd1;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                k_next   = '0;
                if (pend_reg)
                begin
                    cmd.wr_pending = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (k_reg == sts.last_idx)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // memory read runs one step ahead of the mixer
        cmd.rd_round = round_next;
        cmd.rd_hs    = hs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            hs_reg    <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            hs_reg    <= hs_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && out_valid))
        else $error("input and output handshakes overlap");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (k_reg == sts.last_idx)) |=> (state_reg == S_IDLE))
        else $error("engine not idle after last digest item");

    a_mix_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MIX) && last_step) |=> (state_reg == S_FOLD))
        else $error("compression did not end after ten rounds");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (k_reg <= sts.last_idx))
        else $error("digest word index beyond digest length");

endmodule

// ===== design/b2s_datapath.sv =====
`timescale 1ns / 1ps

module b2s_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  b2s_pkg::cmd_t   cmd,
    output b2s_pkg::sts_t   sts,
    input  logic [7:0]      data_byte,
    input  logic            cfg_fire,
    input  logic [5:0]      cfg_data,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);

    logic [5:0]  dl_reg;
    logic [5:0]  dl_new;
    logic        cfg_ok;
    logic        restart;
    logic [31:0] chain_reg [8];
    logic [6:0]  cnt_reg;
    logic [63:0] t_reg;
    logic        final_reg;
    logic [7:0]  hold_reg;

    logic [7:0]  lane_mem [4][16];
    logic [7:0]  rd_reg [4];
    logic [3:0]  raddr_reg;
    logic [3:0]  raddr;
    logic        mem_we;
    logic [5:0]  mem_ptr;
    logic [7:0]  mem_byte;
    logic [31:0] m_word;

    logic [31:0] a_reg [4];
    logic [31:0] b_reg [4];
    logic [31:0] c_reg [4];
    logic [31:0] d_reg [4];
    logic [31:0] na [4];
    logic [31:0] nb [4];
    logic [31:0] nc [4];
    logic [31:0] nd [4];
    logic        diag;
    logic        half;
    logic [31:0] ga, gb, gc, gd;
    logic [31:0] sa, sd, sc, sb;
    logic [31:0] xd, xb;

    logic [1:0]  extra;
    logic [31:0] tail_mask;

    assign cfg_ok  = cfg_fire && (cfg_data >= 6'd1) && (cfg_data <= b2s_pkg::DL_MAX);
    assign dl_new  = cfg_ok ? cfg_data : dl_reg;
    assign restart = cfg_ok || cmd.restart;

    assign sts.full     = (cnt_reg == 7'(b2s_pkg::BLOCK_BYTES));
    assign sts.last_idx = 3'((dl_reg - 6'd1) >> 2);

    // block buffer, one lane per byte of a message word
    assign mem_we   = cmd.wr_byte || cmd.wr_pending;
    assign mem_ptr  = cmd.wr_pending ? 6'd0 : cnt_reg[5:0];
    assign mem_byte = cmd.wr_pending ? hold_reg : data_byte;
    assign raddr    = b2s_pkg::sigma_idx(cmd.rd_round, cmd.rd_hs);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lane_mem[mem_ptr[1:0]][mem_ptr[5:2]] <= mem_byte;
        end
        for (int l = 0; l < 4; l++)
        begin
            rd_reg[l] <= lane_mem[l][raddr];
        end
        raddr_reg <= raddr;
    end

    // bytes past the fill level read as zero padding
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if ({1'b0, raddr_reg, 2'(l)} < cnt_reg)
            begin
                m_word[8*l +: 8] = rd_reg[l];
            end
            else
            begin
                m_word[8*l +: 8] = 8'h00;
            end
        end
    end

    // half a G mix per cycle on fixed row positions; rows rotate after each G
    assign diag = cmd.hs[3];
    assign half = cmd.hs[0];
    assign ga   = a_reg[0];
    assign gb   = diag ? b_reg[1] : b_reg[0];
    assign gc   = diag ? c_reg[2] : c_reg[0];
    assign gd   = diag ? d_reg[3] : d_reg[0];
    assign sa   = ga + gb + m_word;
    assign xd   = gd ^ sa;
    assign sd   = half ? {xd[7:0], xd[31:8]} : {xd[15:0], xd[31:16]};
    assign sc   = gc + sd;
    assign xb   = gb ^ sc;
    assign sb   = half ? {xb[6:0], xb[31:7]} : {xb[11:0], xb[31:12]};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            na[i] = a_reg[i];
            nb[i] = b_reg[i];
            nc[i] = c_reg[i];
            nd[i] = d_reg[i];
        end
        na[0] = sa;
        if (diag)
        begin
            nb[1] = sb;
            nc[2] = sc;
            nd[3] = sd;
        end
        else
        begin
            nb[0] = sb;
            nc[0] = sc;
            nd[0] = sd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_v)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a_reg[i] <= chain_reg[i];
                b_reg[i] <= chain_reg[4 + i];
                c_reg[i] <= b2s_pkg::IV[i];
            end
            d_reg[0] <= b2s_pkg::IV[4] ^ t_reg[31:0];
            d_reg[1] <= b2s_pkg::IV[5] ^ t_reg[63:32];
            d_reg[2] <= b2s_pkg::IV[6] ^ {32{final_reg}};
            d_reg[3] <= b2s_pkg::IV[7];
        end
        else if (cmd.mix)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (half)
                begin
                    a_reg[i] <= na[(i + 1) % 4];
                    b_reg[i] <= nb[(i + 1) % 4];
                    c_reg[i] <= nc[(i + 1) % 4];
                    d_reg[i] <= nd[(i + 1) % 4];
                end
                else
                begin
                    a_reg[i] <= na[i];
                    b_reg[i] <= nb[i];
                    c_reg[i] <= nc[i];
                    d_reg[i] <= nd[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_comp)
        begin
            hold_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg    <= b2s_pkg::DL_RESET;
            cnt_reg   <= '0;
            t_reg     <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= b2s_pkg::IV[i];
            end
            chain_reg[0] <= b2s_pkg::IV[0] ^ b2s_pkg::PARAM_FANOUT_DEPTH
                            ^ {26'd0, b2s_pkg::DL_RESET};
        end
        else
        begin
            dl_reg <= dl_new;
            if (restart)
            begin
                cnt_reg   <= '0;
                t_reg     <= '0;
                final_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= b2s_pkg::IV[i];
                end
                chain_reg[0] <= b2s_pkg::IV[0] ^ b2s_pkg::PARAM_FANOUT_DEPTH
                                ^ {26'd0, dl_new};
            end
            else
            begin
                if (cmd.wr_byte)
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                else if (cmd.wr_pending)
                begin
                    cnt_reg <= 7'd1;
                end
                if (cmd.start_comp)
                begin
                    final_reg <= cmd.is_final;
                    t_reg     <= t_reg + (cmd.is_final ? {57'd0, cnt_reg}
                                                       : 64'(b2s_pkg::BLOCK_BYTES));
                end
                if (cmd.fold)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        chain_reg[i]     <= chain_reg[i] ^ a_reg[i] ^ c_reg[i];
                        chain_reg[4 + i] <= chain_reg[4 + i] ^ b_reg[i] ^ d_reg[i];
                    end
                end
            end
        end
    end

    assign extra = 2'(~dl_reg + 6'd1);

    always_comb
    begin
        unique case (extra)
            2'd0:    tail_mask = 32'hffffffff;
            2'd1:    tail_mask = 32'h00ffffff;
            2'd2:    tail_mask = 32'h0000ffff;
            default: tail_mask = 32'h000000ff;
        endcase
    end

    assign last_word   = (cmd.out_idx == sts.last_idx);
    assign word_index  = cmd.out_idx;
    assign digest_word = chain_reg[cmd.out_idx] & (last_word ? tail_mask : 32'hffffffff);

endmodule

// ===== design/blake2s_hash_engine.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Payload                                  Accepted when
// msg       in    command, data_byte                       msg.valid & msg.ready
// digest    out   digest_word, word_index, last_word       digest.valid & digest.ready
// cfg       in    out_len                                  cfg.valid & cfg.ready
//
// A byte arriving on a part-filled block is written into it, and msg stays ready.
// A byte arriving on a full block, or a finish, starts a compression: one G unit
// does half a G mix per cycle through the ten rounds, between setup and fold.
// Finish then offers one digest item per cycle, held while digest.ready is low.
// Reset loads the chain for a 32-byte digest; cfg is always ready.

module blake2s_hash_engine (
    input  logic               clk,
    input  logic               rst_n,
    b2s_msg_if.sink            msg,
    b2s_digest_if.source       digest,
    b2s_cfg_if.sink            cfg
);

    b2s_pkg::cmd_t cmd;
    b2s_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    b2s_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg.valid),
        .msg_command (msg.command),
        .msg_ready   (msg.ready),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    b2s_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .data_byte   (msg.data_byte),
        .cfg_fire    (cfg.valid),
        .cfg_data    (cfg.out_len),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

endmodule
